[hw/rtl/scf_pkg.sv]
// Shared types, constants and helpers for the stereo crossfeed filter.
package scf_pkg;

   localparam int COEF_W        = 32;                  // signed coefficient as multiplied
   localparam int UCOEF_W       = 31;                  // width of the unsigned coefficient regs
   localparam int DIGIT_W       = 4;                   // coefficient bits consumed per cycle
   localparam int DIGITS        = COEF_W / DIGIT_W;
   localparam int DIGIT_IDX_W   = $clog2(DIGITS);
   localparam int DIGIT_VAL_W   = DIGIT_W + 1;         // digit with sign bit
   localparam int LOW_W         = COEF_W - DIGIT_W;    // product bits shifted out of the lane
   localparam int TERMS         = 3;                   // most products summed in one filter
   localparam int TERM_W        = $clog2(TERMS);
   localparam int HEADROOM_BITS = 8;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_LP_IN,
      REG_LP_FB,
      REG_BO_IN,
      REG_BO_DLY,
      REG_BO_FB,
      REG_GAIN
   } csr_reg_type;

   // input transaction kind carried on tuser
   typedef enum logic {
      ACT_PROCESS,
      ACT_CLEAR
   } action_type;

   typedef enum logic [1:0] {
      PH_LP,
      PH_BO,
      PH_OUT
   } phase_type;

   typedef struct packed {
      logic [UCOEF_W-1:0] lowpass_input;
      logic [UCOEF_W-1:0] lowpass_feedback;
      logic [UCOEF_W-1:0] boost_input;
      logic [COEF_W-1:0]  boost_delayed;
      logic [UCOEF_W-1:0] boost_feedback;
      logic [UCOEF_W-1:0] gain;
   } coef_set_type;

   typedef struct packed {
      logic                   clear;
      logic                   add;
      logic                   shift;
      logic [DIGIT_VAL_W-1:0] digit;
   } lane_ctl_type;

   typedef struct packed {
      phase_type         phase;
      logic [TERM_W-1:0] term;
      logic              capture;
      logic              idle;
   } seq_status_type;

   // fraction bits of the filter state above a sample
   function automatic int state_frac_bits(int sample_bits, int state_bits);
      int frac;
      frac = 0;
      if (state_bits - sample_bits > HEADROOM_BITS) begin
         frac = state_bits - sample_bits - HEADROOM_BITS;
      end
      return frac;
   endfunction

endpackage

[hw/rtl/scf_lane.sv]
// One channel lane: digit-serial multiply-accumulate with state and output finishing.
module scf_lane #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 30,
   parameter int STATE_BITS     = 40
) (
   input  logic                      clock,
   input  scf_pkg::lane_ctl_type     lane_ctl,
   input  logic [STATE_BITS:0]       multiplicand,
   output logic [STATE_BITS-1:0]     fit_value,
   output logic [SAMPLE_BITS-1:0]    out_value,
   output logic                      out_clip
);
   import scf_pkg::*;

   localparam int STATE_FRAC = state_frac_bits(SAMPLE_BITS, STATE_BITS);
   localparam int MW         = STATE_BITS + 1;
   localparam int ACC_W      = MW + 6;
   localparam int FW         = ACC_W + LOW_W;
   localparam int FIT_W      = FW - COEF_FRAC_BITS;
   localparam int OUT_SHIFT  = COEF_FRAC_BITS + STATE_FRAC;
   localparam int QO_W       = FW - OUT_SHIFT;
   localparam logic signed [QO_W-1:0] OUT_MAX =
      {{(QO_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [QO_W-1:0] OUT_MIN = -OUT_MAX;

   logic signed [ACC_W-1:0] acc_ff, acc_in, prod, sum;
   logic [LOW_W-1:0]        low_ff, low_in;
   logic signed [FW-1:0]    full;
   logic signed [FIT_W-1:0] fit_q;
   logic                    fit_ok;
   logic signed [QO_W-1:0]  out_q, out_r, out_t;
   logic                    round_up;

   always_comb begin
      prod = $signed({{(ACC_W-DIGIT_VAL_W){lane_ctl.digit[DIGIT_VAL_W-1]}}, lane_ctl.digit})
           * $signed({{(ACC_W-MW){multiplicand[MW-1]}}, multiplicand});
      sum  = acc_ff + prod;
      acc_in = acc_ff;
      low_in = low_ff;
      if (lane_ctl.clear) begin
         acc_in = '0;
         low_in = '0;
      end else if (lane_ctl.add) begin
         if (lane_ctl.shift) begin
            acc_in = sum >>> DIGIT_W;
            low_in = {sum[DIGIT_W-1:0], low_ff[LOW_W-1:DIGIT_W]};
         end else begin
            acc_in = sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      low_ff <= low_in;
   end

   // exact sum of products, weight of the low bit is one
   assign full = $signed({acc_ff, low_ff});

   // filter state: floor shift, then saturate to the state width
   always_comb begin
      fit_q  = full[FW-1:COEF_FRAC_BITS];
      fit_ok = (&fit_q[FIT_W-1:STATE_BITS-1]) | ~(|fit_q[FIT_W-1:STATE_BITS-1]);
      if (fit_ok) begin
         fit_value = fit_q[STATE_BITS-1:0];
      end else begin
         fit_value = {fit_q[FIT_W-1], {(STATE_BITS-1){~fit_q[FIT_W-1]}}};
      end
   end

   // output sample: shift toward zero, symmetric clip
   always_comb begin
      out_q    = full[FW-1:OUT_SHIFT];
      round_up = full[FW-1] & (|full[OUT_SHIFT-1:0]);
      out_r    = out_q + QO_W'(round_up);
      out_clip = 1'b0;
      out_t    = out_r;
      if (out_r > OUT_MAX) begin
         out_t    = OUT_MAX;
         out_clip = 1'b1;
      end else if (out_r < OUT_MIN) begin
         out_t    = OUT_MIN;
         out_clip = 1'b1;
      end
      out_value = out_t[SAMPLE_BITS-1:0];
   end

endmodule

[hw/rtl/scf_seq.sv]
// Sequencer: filter phases, term interleave and coefficient digit shift registers.
module scf_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    out_free,
   input  scf_pkg::coef_set_type   coefs,
   output scf_pkg::lane_ctl_type   lane_ctl,
   output scf_pkg::seq_status_type status
);
   import scf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_LATCH
   } seq_state_type;

   seq_state_type          state_ff;
   phase_type              phase_ff;
   logic [TERM_W-1:0]      term_ff;
   logic [DIGIT_IDX_W-1:0] digit_ff;
   logic [COEF_W-1:0]      cf_ff [TERMS];
   logic [TERM_W-1:0]      last_term;
   logic [DIGIT_W-1:0]     raw_digit;
   logic                   last_digit;
   logic                   term_end;
   logic                   proceed;

   always_comb begin
      case (phase_ff)
         PH_LP:   last_term = TERM_W'(1);
         PH_BO:   last_term = TERM_W'(2);
         PH_OUT:  last_term = '0;
         default: last_term = '0;
      endcase
      case (term_ff)
         TERM_W'(0): raw_digit = cf_ff[0][DIGIT_W-1:0];
         TERM_W'(1): raw_digit = cf_ff[1][DIGIT_W-1:0];
         default:    raw_digit = cf_ff[2][DIGIT_W-1:0];
      endcase
      last_digit = (digit_ff == DIGIT_IDX_W'(DIGITS - 1));
      term_end   = (term_ff == last_term);
      proceed    = (phase_ff != PH_OUT) || out_free;

      // top digit carries the coefficient sign
      lane_ctl.digit = last_digit ? {raw_digit[DIGIT_W-1], raw_digit} : {1'b0, raw_digit};
      lane_ctl.add   = (state_ff == ST_RUN);
      lane_ctl.shift = (state_ff == ST_RUN) && term_end && !last_digit;
      lane_ctl.clear = (state_ff == ST_IDLE) || ((state_ff == ST_LATCH) && proceed);

      status.phase   = phase_ff;
      status.term    = term_ff;
      status.capture = (state_ff == ST_LATCH) && proceed;
      status.idle    = (state_ff == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_LP;
         term_ff  <= '0;
         digit_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_RUN;
                  phase_ff <= PH_LP;
                  term_ff  <= '0;
                  digit_ff <= '0;
                  cf_ff[0] <= {1'b0, coefs.lowpass_input};
                  cf_ff[1] <= {1'b0, coefs.lowpass_feedback};
                  cf_ff[2] <= '0;
               end
            end
            ST_RUN: begin
               if (term_end) begin
                  term_ff <= '0;
                  if (last_digit) begin
                     state_ff <= ST_LATCH;
                  end else begin
                     digit_ff <= digit_ff + DIGIT_IDX_W'(1);
                     for (int i = 0; i < TERMS; i++) begin
                        cf_ff[i] <= cf_ff[i] >> DIGIT_W;
                     end
                  end
               end else begin
                  term_ff <= term_ff + TERM_W'(1);
               end
            end
            ST_LATCH: begin
               if (proceed) begin
                  term_ff  <= '0;
                  digit_ff <= '0;
                  case (phase_ff)
                     PH_LP: begin
                        phase_ff <= PH_BO;
                        state_ff <= ST_RUN;
                        cf_ff[0] <= {1'b0, coefs.boost_input};
                        cf_ff[1] <= coefs.boost_delayed;
                        cf_ff[2] <= {1'b0, coefs.boost_feedback};
                     end
                     PH_BO: begin
                        phase_ff <= PH_OUT;
                        state_ff <= ST_RUN;
                        cf_ff[0] <= {1'b0, coefs.gain};
                     end
                     default: begin
                        phase_ff <= PH_LP;
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[hw/rtl/stereo_crossfeed_filter.sv]
// Top level of the stereo crossfeed filter: registers, filter state, lanes and handshake.
//
//  channel  direction  handshake               payload
//  req      in         req_tvalid/req_tready   tdata {right_in, left_in}, tuser action
//  rsp      out        rsp_tvalid/rsp_tready   tdata {right_out, left_out},
//                                              tuser {right_clipped, left_clipped}
//  csr      in         csr_valid/csr_ready     csr_index, csr_data
//
// A new sample pair is accepted only once the last one is through: both channels run in parallel
// lanes, each coefficient is consumed 4 bits per step over 8 steps; the lowpass (2
// products), highboost (3) and output (1) phases run in turn with their products
// interleaved per step, each phase ends in a capture state, and req_tready returns
// after the output capture, once the output register is free.
// A clear transaction zeroes the filter state.
// Reset is synchronous and returns the configuration registers and filter state to zero.
// A stalled rsp holds its result; the next pair may be accepted meanwhile and waits
// at its final capture until the output register is free. csr_ready is always high.
module stereo_crossfeed_filter #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 30,
   parameter int STATE_BITS     = 40
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [SAMPLE_BITS-1:0] left_in, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_in, zero pad above
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   // [0] action
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [SAMPLE_BITS-1:0] left_out, [2*SAMPLE_BITS-1:SAMPLE_BITS] right_out, zero pad above
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    rsp_tdata,
   // [0] left_clipped, [1] right_clipped
   output logic [1:0]                            rsp_tuser,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [2:0]                            csr_index,
   input  logic [31:0]                           csr_data
);
   import scf_pkg::*;

   localparam int TDATA_W    = ((2*SAMPLE_BITS+7)/8)*8;
   localparam int STATE_FRAC = state_frac_bits(SAMPLE_BITS, STATE_BITS);
   localparam int MW         = STATE_BITS + 1;

   coef_set_type           coef_ff;
   lane_ctl_type           lane_ctl;
   seq_status_type         status;
   logic [SAMPLE_BITS-1:0] x_ff [2];
   logic [SAMPLE_BITS-1:0] prev_ff [2];
   logic [STATE_BITS-1:0]  lp_ff [2];
   logic [STATE_BITS-1:0]  bo_ff [2];
   logic [MW-1:0]          mult [2];
   logic [STATE_BITS-1:0]  fit_value [2];
   logic [SAMPLE_BITS-1:0] out_value [2];
   logic                   out_clip [2];
   logic                   rsp_tvalid_ff;
   logic [SAMPLE_BITS-1:0] rsp_left_ff, rsp_right_ff;
   logic [1:0]             rsp_clip_ff;
   logic                   req_take, start, out_free;

   assign csr_ready  = 1'b1;
   assign req_tready = status.idle;
   assign req_take   = req_tvalid && req_tready;
   assign start      = req_take && (req_tuser != ACT_CLEAR);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LP_IN:  coef_ff.lowpass_input    <= csr_data[UCOEF_W-1:0];
            REG_LP_FB:  coef_ff.lowpass_feedback <= csr_data[UCOEF_W-1:0];
            REG_BO_IN:  coef_ff.boost_input      <= csr_data[UCOEF_W-1:0];
            REG_BO_DLY: coef_ff.boost_delayed    <= csr_data[COEF_W-1:0];
            REG_BO_FB:  coef_ff.boost_feedback   <= csr_data[UCOEF_W-1:0];
            REG_GAIN:   coef_ff.gain             <= csr_data[UCOEF_W-1:0];
            default: ;
         endcase
      end
   end

   scf_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .coefs    (coef_ff),
      .lane_ctl (lane_ctl),
      .status   (status)
   );

   for (genvar ch = 0; ch < 2; ch++) begin : g_lane
      logic signed [MW-1:0] xs, ps, lps, bos, lpo, cross_sum;

      always_comb begin
         xs    = $signed({{(MW-SAMPLE_BITS){x_ff[ch][SAMPLE_BITS-1]}}, x_ff[ch]}) <<< STATE_FRAC;
         ps    = $signed({{(MW-SAMPLE_BITS){prev_ff[ch][SAMPLE_BITS-1]}}, prev_ff[ch]})
                 <<< STATE_FRAC;
         lps   = $signed({lp_ff[ch][STATE_BITS-1], lp_ff[ch]});
         bos   = $signed({bo_ff[ch][STATE_BITS-1], bo_ff[ch]});
         lpo   = $signed({lp_ff[1-ch][STATE_BITS-1], lp_ff[1-ch]});
         cross_sum = bos + lpo;
         case (status.phase)
            PH_LP: begin
               mult[ch] = (status.term == '0) ? xs : lps;
            end
            PH_BO: begin
               case (status.term)
                  TERM_W'(0): mult[ch] = xs;
                  TERM_W'(1): mult[ch] = ps;
                  default:    mult[ch] = bos;
               endcase
            end
            PH_OUT:  mult[ch] = cross_sum;
            default: mult[ch] = '0;
         endcase
      end

      scf_lane #(
         .SAMPLE_BITS    (SAMPLE_BITS),
         .COEF_FRAC_BITS (COEF_FRAC_BITS),
         .STATE_BITS     (STATE_BITS)
      ) u_lane (
         .clock        (clock),
         .lane_ctl     (lane_ctl),
         .multiplicand (mult[ch]),
         .fit_value    (fit_value[ch]),
         .out_value    (out_value[ch]),
         .out_clip     (out_clip[ch])
      );
   end

   // filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < 2; ch++) begin
            lp_ff[ch]   <= '0;
            bo_ff[ch]   <= '0;
            prev_ff[ch] <= '0;
         end
      end else if (req_take && (req_tuser == ACT_CLEAR)) begin
         for (int ch = 0; ch < 2; ch++) begin
            lp_ff[ch]   <= '0;
            bo_ff[ch]   <= '0;
            prev_ff[ch] <= '0;
         end
      end else if (status.capture) begin
         for (int ch = 0; ch < 2; ch++) begin
            if (status.phase == PH_LP) begin
               lp_ff[ch] <= fit_value[ch];
            end
            if (status.phase == PH_BO) begin
               bo_ff[ch]   <= fit_value[ch];
               prev_ff[ch] <= x_ff[ch];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff[0] <= req_tdata[SAMPLE_BITS-1:0];
         x_ff[1] <= req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (status.capture && (status.phase == PH_OUT)) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (status.capture && (status.phase == PH_OUT)) begin
         rsp_left_ff  <= out_value[0];
         rsp_right_ff <= out_value[1];
         rsp_clip_ff  <= {out_clip[1], out_clip[0]};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = TDATA_W'({rsp_right_ff, rsp_left_ff});
   assign rsp_tuser  = rsp_clip_ff;

   localparam logic [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-2){1'b0}}, 1'b1};

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      status.capture && (status.phase == PH_OUT) |-> !rsp_tvalid_ff || rsp_tready)
      else $error("result captured over an untaken result");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      start |=> !req_tready)
      else $error("ready high right after a sample pair was accepted");

   a_rsp_from_capture: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(status.capture && (status.phase == PH_OUT)))
      else $error("result raised without an output capture");

   a_clip_full_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_left_ff == FULL_POS) || (rsp_left_ff == FULL_NEG))
      else $error("left clip flag set on a sample below full scale");

endmodule

[bench/stereo_crossfeed_filter_tb.sv]
// Self-checking bench for the stereo crossfeed filter: random stream traffic against a predictor.
module stereo_crossfeed_filter_tb;
   import scf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS    = 24;
   localparam int COEF_FRAC_BITS = 30;
   localparam int STATE_BITS     = 40;
   localparam int STATE_FRAC     = STATE_BITS - SAMPLE_BITS - HEADROOM_BITS;
   localparam int OUT_SHIFT      = COEF_FRAC_BITS + STATE_FRAC;
   localparam int DATA_W         = ((2*SAMPLE_BITS+7)/8)*8;

   localparam longint SAMPLE_SCALE = 64'sd1 <<< STATE_FRAC;
   localparam longint STATE_MAX    = (64'sd1 <<< (STATE_BITS-1)) - 1;
   localparam longint STATE_MIN    = -STATE_MAX - 1;
   localparam longint SAMPLE_MAX   = (64'sd1 <<< (SAMPLE_BITS-1)) - 1;
   localparam longint ROUND_BIAS   = (64'sd1 <<< OUT_SHIFT) - 1;

   localparam logic [SAMPLE_BITS-1:0] FULL_POS = 24'h7F_FFFF;
   localparam logic [SAMPLE_BITS-1:0] FULL_NEG = 24'h80_0000;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int DRAIN_CYCLES    = 64;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int MAX_REPORTS     = 10;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [SAMPLE_BITS-1:0] left_out;
      logic [SAMPLE_BITS-1:0] right_out;
      logic                   left_clip;
      logic                   right_clip;
   } pair_result_type;

   class crossfeed_scoreboard_type;
      longint lp_in, lp_fb, bo_in, bo_dly, bo_fb, gain;
      longint lp_state[2], bo_state[2], last_x[2];
      pair_result_type pending[$];
      int errors, pairs, clears, clipped, saturated, checked;

      function void set_coef(csr_reg_type idx, logic [31:0] value);
         case (idx)
            REG_LP_IN:  lp_in  = longint'(value & 32'h7FFF_FFFF);
            REG_LP_FB:  lp_fb  = longint'(value & 32'h7FFF_FFFF);
            REG_BO_IN:  bo_in  = longint'(value & 32'h7FFF_FFFF);
            REG_BO_DLY: bo_dly = longint'($signed(value));
            REG_BO_FB:  bo_fb  = longint'(value & 32'h7FFF_FFFF);
            REG_GAIN:   gain   = longint'(value & 32'h7FFF_FFFF);
            default: ;
         endcase
      endfunction

      function wide_type product(longint a, longint b);
         wide_type wa, wb;
         wa = wide_type'(a);
         wb = wide_type'(b);
         return wa * wb;
      endfunction

      // drop coefficient fraction (floor), saturate to the state width
      function longint to_state(wide_type acc);
         wide_type v;
         v = acc >>> COEF_FRAC_BITS;
         if (v < STATE_MIN) begin
            saturated++;
            return STATE_MIN;
         end
         if (v > STATE_MAX) begin
            saturated++;
            return STATE_MAX;
         end
         return longint'(v);
      endfunction

      // gain, truncate toward zero, symmetric clip
      function logic [SAMPLE_BITS-1:0] to_sample(longint sum, output logic hit);
         wide_type p;
         longint   y;
         p = product(gain, sum);
         if (p < 0) p = p + ROUND_BIAS;
         p = p >>> OUT_SHIFT;
         hit = 1'b1;
         if (p < -SAMPLE_MAX) y = -SAMPLE_MAX;
         else if (p > SAMPLE_MAX) y = SAMPLE_MAX;
         else begin
            y = longint'(p);
            hit = 1'b0;
         end
         if (hit) clipped++;
         return y[SAMPLE_BITS-1:0];
      endfunction

      function void note_item(action_type act, logic [SAMPLE_BITS-1:0] left,
                              logic [SAMPLE_BITS-1:0] right);
         longint          x[2];
         pair_result_type res;
         if (act == ACT_CLEAR) begin
            for (int ch = 0; ch < 2; ch++) begin
               lp_state[ch] = 0;
               bo_state[ch] = 0;
               last_x[ch]   = 0;
            end
            clears++;
            return;
         end
         x[0] = longint'($signed(left));
         x[1] = longint'($signed(right));
         for (int ch = 0; ch < 2; ch++) begin
            lp_state[ch] = to_state(product(lp_in, x[ch] * SAMPLE_SCALE)
                                    + product(lp_fb, lp_state[ch]));
         end
         for (int ch = 0; ch < 2; ch++) begin
            bo_state[ch] = to_state(product(bo_in, x[ch] * SAMPLE_SCALE)
                                    + product(bo_dly, last_x[ch] * SAMPLE_SCALE)
                                    + product(bo_fb, bo_state[ch]));
            last_x[ch] = x[ch];
         end
         // each channel's highboost gets the opposite channel's lowpass
         res.left_out  = to_sample(bo_state[0] + lp_state[1], res.left_clip);
         res.right_out = to_sample(bo_state[1] + lp_state[0], res.right_clip);
         pending.push_back(res);
         pairs++;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("ERROR: %s", msg);
      endfunction

      function void compare(string field, logic [SAMPLE_BITS-1:0] want,
                            logic [SAMPLE_BITS-1:0] got);
         if (want !== got)
            report($sformatf("result %0d %s: expected %h, got %h", checked, field, want, got));
      endfunction

      function void check_result(logic [DATA_W-1:0] data, logic [1:0] flags);
         pair_result_type want;
         if (pending.size() == 0) begin
            report($sformatf("result with nothing pending: tdata %h tuser %b", data, flags));
            return;
         end
         want = pending.pop_front();
         checked++;
         compare("left_out", want.left_out, data[SAMPLE_BITS-1:0]);
         compare("right_out", want.right_out, data[2*SAMPLE_BITS-1:SAMPLE_BITS]);
         compare("left_clipped", SAMPLE_BITS'(want.left_clip), SAMPLE_BITS'(flags[0]));
         compare("right_clipped", SAMPLE_BITS'(want.right_clip), SAMPLE_BITS'(flags[1]));
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata;   // [23:0] left_in, [47:24] right_in
   logic                   req_tuser;   // [0] action
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [DATA_W-1:0]      rsp_tdata;   // [23:0] left_out, [47:24] right_out
   logic [1:0]             rsp_tuser;   // [0] left_clipped, [1] right_clipped
   logic                   csr_valid;
   logic                   csr_ready;
   logic [2:0]             csr_index;
   logic [31:0]            csr_data;

   crossfeed_scoreboard_type sb = new();
   int  cycle_count = 0;
   int  coef_sets = 0;
   int  rsp_stretch = 0;
   bit  calm = 1'b0;
   bit  burst = 1'b0;
   bit  hold_off_request = 1'b0;
   logic [SAMPLE_BITS-1:0] last_left = '0, last_right = '0;

   stereo_crossfeed_filter #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .STATE_BITS     (STATE_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, sb.outstanding());
         $display("Regression FAIL");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 4);
      if (r < 98) return $urandom_range(5, 20);
      return $urandom_range(21, 100);
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] pick_sample();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0: return FULL_POS;
         1: return FULL_NEG;
         2: return '0;
         3: return {{(SAMPLE_BITS-9){r[31]}}, r[8:0]};
         default: return r[SAMPLE_BITS-1:0];
      endcase
   endfunction

   function automatic logic [30:0] pick_coef();
      if ($urandom_range(0, 3) == 0) return 31'($urandom());
      return 31'($urandom_range(0, 32'h4000_0000));
   endfunction

   // result side: checks every transaction, stalls at random
   always @(posedge clock) begin
      if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) sb.check_result(rsp_tdata, rsp_tuser);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         rsp_tready <= 1'b0;
         rsp_stretch = HOLD_OFF_CYCLES - 1;
      end else if (rsp_stretch > 0) begin
         rsp_stretch--;
      end else if (rsp_tready && !calm) begin
         int stall;
         stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stretch = stall - 1;
         end else begin
            rsp_stretch = $urandom_range(0, 10);
         end
      end else begin
         rsp_tready <= 1'b1;
         rsp_stretch = $urandom_range(0, 10);
      end
   end

   task automatic send_item(action_type act, logic [SAMPLE_BITS-1:0] left,
                            logic [SAMPLE_BITS-1:0] right);
      int gap;
      gap = (burst || calm) ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {right, left};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_item(act, left, right);
   endtask

   task automatic write_reg(csr_reg_type idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_coef(idx, value);
   endtask

   task automatic program_coefs(coef_set_type c);
      write_reg(REG_LP_IN,  {1'b0, c.lowpass_input});
      write_reg(REG_LP_FB,  {1'b0, c.lowpass_feedback});
      write_reg(REG_BO_IN,  {1'b0, c.boost_input});
      write_reg(REG_BO_DLY, c.boost_delayed);
      write_reg(REG_BO_FB,  {1'b0, c.boost_feedback});
      write_reg(REG_GAIN,   {1'b0, c.gain});
      csr_valid <= 1'b0;
      coef_sets++;
   endtask

   // let every pending result come out, then give a trailing clear time to settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_items(int count);
      action_type act;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         act = ($urandom_range(0, 31) == 0) ? ACT_CLEAR : ACT_PROCESS;
         // held values let the filters settle toward their steady state
         if ($urandom_range(0, 3) != 0) begin
            last_left  = pick_sample();
            last_right = pick_sample();
         end
         send_item(act, last_left, last_right);
      end
      calm = 1'b0;
   endtask

   initial begin
      coef_set_type c;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= ACT_PROCESS;
      csr_valid  <= 1'b0;
      csr_index  <= REG_LP_IN;
      csr_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // typical crossfeed: lowpass 0.1/0.9, highboost 1.2/-0.9/0.7, gain 0.8
      c = '{lowpass_input: 31'd107374182, lowpass_feedback: 31'd966367642,
            boost_input: 31'd1288490189, boost_delayed: -32'sd966367642,
            boost_feedback: 31'd751619277, gain: 31'd858993459};
      program_coefs(c);

      send_item(ACT_CLEAR, '0, '0);
      send_item(ACT_PROCESS, FULL_POS, FULL_POS);
      send_item(ACT_PROCESS, FULL_POS, FULL_POS);
      send_item(ACT_PROCESS, FULL_NEG, FULL_NEG);
      send_item(ACT_PROCESS, FULL_NEG, FULL_NEG);
      send_item(ACT_PROCESS, FULL_POS, FULL_NEG);
      send_item(ACT_PROCESS, FULL_NEG, FULL_POS);
      send_item(ACT_PROCESS, '0, '0);
      send_item(ACT_PROCESS, 24'h00_0001, 24'hFF_FFFF);
      send_item(ACT_PROCESS, 24'hFF_FFFF, 24'h00_0001);
      send_item(ACT_PROCESS, 24'h55_5555, 24'hAA_AAAA);
      send_item(ACT_PROCESS, 24'hAA_AAAA, 24'h55_5555);
      send_item(ACT_CLEAR, FULL_POS, FULL_NEG);
      send_item(ACT_CLEAR, '0, '0);
      send_item(ACT_PROCESS, FULL_POS, '0);
      send_item(ACT_PROCESS, '0, FULL_NEG);
      send_item(ACT_PROCESS, FULL_NEG, FULL_NEG);
      send_item(ACT_CLEAR, '0, '0);
      send_item(ACT_PROCESS, FULL_NEG, FULL_POS);
      random_items(100);

      // receiver holds off while the sender keeps pushing: input must back up
      hold_off_request = 1'b1;
      burst = 1'b1;
      repeat (12) send_item(ACT_PROCESS, pick_sample(), pick_sample());
      burst = 1'b0;
      drain();

      // every coefficient at its top, delayed tap most negative: saturation and clipping
      c = '{lowpass_input: '1, lowpass_feedback: '1, boost_input: '1,
            boost_delayed: 32'h8000_0000, boost_feedback: '1, gain: '1};
      program_coefs(c);
      send_item(ACT_PROCESS, FULL_NEG, FULL_NEG);
      send_item(ACT_PROCESS, FULL_NEG, FULL_NEG);
      random_items(90);
      drain();

      // filters off, gain zero, delayed tap at its positive top
      c = '{lowpass_input: '0, lowpass_feedback: '0, boost_input: '0,
            boost_delayed: 32'h7FFF_FFFF, boost_feedback: '0, gain: '0};
      program_coefs(c);
      random_items(60);
      drain();

      for (int s = 0; s < 5; s++) begin
         c.lowpass_input    = pick_coef();
         c.lowpass_feedback = pick_coef();
         c.boost_input      = pick_coef();
         c.boost_delayed    = $urandom();
         c.boost_feedback   = pick_coef();
         c.gain             = pick_coef();
         program_coefs(c);
         random_items(100);
         drain();
      end

      $display("Covered %0d sample pairs and %0d clear transactions over %0d coefficient sets",
               sb.pairs, sb.clears, coef_sets);
      $display("%0d results checked, %0d channel outputs clipped, %0d filter states saturated",
               sb.checked, sb.clipped, sb.saturated);
      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
